>>> rtl/uas_pkg.sv
// ----------------------------------------------------------------------------
// uas_pkg
// Shared types and constants for the upwind advection stencil.
// ----------------------------------------------------------------------------
package uas_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int COURANT_BITS   = 17;
    localparam int COLS_REG_BITS  = 11;
    localparam int ROWS_REG_BITS  = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 17;
    localparam int FRAC_BITS      = 16;

    localparam logic [COURANT_BITS-1:0]  COURANT_ONE   = 17'd65536;
    localparam logic [COURANT_BITS-1:0]  COURANT_RESET = 17'd32768;
    localparam logic [COLS_REG_BITS-1:0] COLS_RESET    = 11'd1024;
    localparam logic [ROWS_REG_BITS-1:0] ROWS_RESET    = 16'd1024;

    localparam logic [CFG_INDEX_BITS-1:0] REG_X_COURANT    = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_COURANT    = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLUMNS = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS    = 8'd3;

    typedef struct packed {
        logic valid;
        logic last;
    } uas_tag_t;

endpackage

>>> rtl/uas_update.sv
// ----------------------------------------------------------------------------
// uas_update
// Two-stage cell update: Courant products, then sum, round and saturate.
// ----------------------------------------------------------------------------
module uas_update #(
    parameter int SAMPLE_BITS = uas_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  advance,
    input  uas_pkg::uas_tag_t                     in_tag,
    input  logic signed [SAMPLE_BITS-1:0]         in_u,
    input  logic signed [SAMPLE_BITS-1:0]         in_left,
    input  logic signed [SAMPLE_BITS-1:0]         in_below,
    input  logic [uas_pkg::COURANT_BITS-1:0]      x_courant,
    input  logic [uas_pkg::COURANT_BITS-1:0]      y_courant,
    output uas_pkg::uas_tag_t                     out_tag,
    output logic signed [SAMPLE_BITS-1:0]         out_value
);

    localparam int PW = SAMPLE_BITS + uas_pkg::COURANT_BITS + 2;
    localparam int AW = SAMPLE_BITS + uas_pkg::COURANT_BITS + 4;
    localparam int FB = uas_pkg::FRAC_BITS;

    logic signed [uas_pkg::COURANT_BITS:0] cx_s;
    logic signed [uas_pkg::COURANT_BITS:0] cy_s;
    logic signed [SAMPLE_BITS:0]           dx;
    logic signed [SAMPLE_BITS:0]           dy;
    logic signed [PW-1:0]                  px_next;
    logic signed [PW-1:0]                  py_next;

    logic signed [PW-1:0]          px_reg;
    logic signed [PW-1:0]          py_reg;
    logic signed [SAMPLE_BITS-1:0] u_reg;
    uas_pkg::uas_tag_t             tag_reg;

    logic signed [AW-1:0]          acc;
    logic signed [AW-1:0]          rs;
    logic                          in_range;
    logic signed [SAMPLE_BITS-1:0] value_next;

    uas_pkg::uas_tag_t             out_tag_reg;
    logic signed [SAMPLE_BITS-1:0] out_value_reg;

    // differences and products
    assign cx_s    = {1'b0, x_courant};
    assign cy_s    = {1'b0, y_courant};
    assign dx      = {in_u[SAMPLE_BITS-1], in_u} - {in_left[SAMPLE_BITS-1], in_left};
    assign dy      = {in_u[SAMPLE_BITS-1], in_u} - {in_below[SAMPLE_BITS-1], in_below};
    assign px_next = cx_s * dx;
    assign py_next = cy_s * dy;

    // u<<16 - px - py, round half up, saturate
    assign acc = (AW'(u_reg) <<< FB) - AW'(px_reg) - AW'(py_reg)
                 + (AW'(1) <<< (FB - 1));
    assign rs  = acc >>> FB;
    assign in_range = (&rs[AW-1:SAMPLE_BITS-1]) || ~(|rs[AW-1:SAMPLE_BITS-1]);
    assign value_next = in_range ? rs[SAMPLE_BITS-1:0]
                                 : {rs[AW-1], {(SAMPLE_BITS-1){~rs[AW-1]}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg     <= '0;
            out_tag_reg <= '0;
        end else if (advance) begin
            tag_reg     <= in_tag;
            out_tag_reg <= tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            px_reg        <= px_next;
            py_reg        <= py_next;
            u_reg         <= in_u;
            out_value_reg <= value_next;
        end
    end

    assign out_tag   = out_tag_reg;
    assign out_value = out_value_reg;

endmodule

>>> rtl/upwind_advection_stencil.sv
// ----------------------------------------------------------------------------
// upwind_advection_stencil
// One explicit first-order upwind step of 2D unit-velocity advection.
// ----------------------------------------------------------------------------
// Cells stream in raster order: a ghost row of grid_columns+1 beats, then
// grid_rows rows of one ghost beat followed by grid_columns interior beats.
// Each interior beat gives one result u - cx*(u-left) - cy*(u-below), rounded
// and saturated; ghost beats give none, and tlast marks the last interior cell.
// The block takes one beat per clock while the output register is not stalled. A
// result reaches the output register through three register stages (row store
// read, multiply stage, round stage into the output register).
// The whole pipeline holds while the output register is full and
// not taken, so s_tready follows m_tready then. The row store is a single
// memory of MAX_COLUMNS+1 entries, read and written at the same column each beat.
module upwind_advection_stencil #(
    parameter int MAX_COLUMNS = uas_pkg::MAX_COLUMNS_DEF,
    parameter int SAMPLE_BITS = uas_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,   // cell_value
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]          m_tdata,   // new_value
    output logic                                      m_tlast,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [uas_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [uas_pkg::CFG_DATA_BITS-1:0]         cfg_data
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int TW = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [uas_pkg::COURANT_BITS-1:0]  x_courant_reg;
    logic [uas_pkg::COURANT_BITS-1:0]  y_courant_reg;
    logic [uas_pkg::COLS_REG_BITS-1:0] grid_columns_reg;
    logic [uas_pkg::ROWS_REG_BITS-1:0] grid_rows_reg;
    logic [uas_pkg::COURANT_BITS-1:0]  cfg_courant;

    logic [CW-1:0]                     cols_eff;
    logic [uas_pkg::ROWS_REG_BITS-1:0] rows_eff;
    logic [CW-1:0]                     col_reg;
    logic [CW-1:0]                     col_next;
    logic [uas_pkg::ROWS_REG_BITS-1:0] row_reg;
    logic [uas_pkg::ROWS_REG_BITS-1:0] row_next;
    logic                              row_end;
    logic                              frame_end;

    logic                              advance;
    logic                              accept;
    logic signed [SAMPLE_BITS-1:0]     cell_u;

    logic signed [SAMPLE_BITS-1:0]     row_mem [MAX_COLUMNS+1];
    logic signed [SAMPLE_BITS-1:0]     below_reg;
    logic signed [SAMPLE_BITS-1:0]     left_reg;
    logic signed [SAMPLE_BITS-1:0]     a_u_reg;
    logic signed [SAMPLE_BITS-1:0]     a_left_reg;
    uas_pkg::uas_tag_t                 a_tag_reg;
    uas_pkg::uas_tag_t                 a_tag_next;

    uas_pkg::uas_tag_t                 out_tag;
    logic signed [SAMPLE_BITS-1:0]     out_value;

    // configuration
    assign cfg_ready   = 1'b1;
    assign cfg_courant = (cfg_data > uas_pkg::COURANT_ONE) ? uas_pkg::COURANT_ONE : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_courant_reg    <= uas_pkg::COURANT_RESET;
            y_courant_reg    <= uas_pkg::COURANT_RESET;
            grid_columns_reg <= uas_pkg::COLS_RESET;
            grid_rows_reg    <= uas_pkg::ROWS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                uas_pkg::REG_X_COURANT:    x_courant_reg <= cfg_courant;
                uas_pkg::REG_Y_COURANT:    y_courant_reg <= cfg_courant;
                uas_pkg::REG_GRID_COLUMNS: begin
                    grid_columns_reg <= cfg_data[uas_pkg::COLS_REG_BITS-1:0];
                end
                uas_pkg::REG_GRID_ROWS: begin
                    grid_rows_reg <= cfg_data[uas_pkg::ROWS_REG_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    // effective grid size
    always_comb begin
        if (grid_columns_reg == '0) begin
            cols_eff = CW'(1);
        end else if (32'(grid_columns_reg) > 32'(MAX_COLUMNS)) begin
            cols_eff = CW'(MAX_COLUMNS);
        end else begin
            cols_eff = CW'(grid_columns_reg);
        end
        rows_eff = (grid_rows_reg == '0) ? uas_pkg::ROWS_REG_BITS'(1) : grid_rows_reg;
    end

    // raster position
    assign row_end   = col_reg >= cols_eff;
    assign frame_end = row_end && (row_reg >= rows_eff);

    always_comb begin
        if (row_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    assign advance = !out_tag.valid || m_tready;
    assign s_tready = advance;
    assign accept  = s_tvalid && s_tready;
    assign cell_u  = s_tdata[SAMPLE_BITS-1:0];

    assign a_tag_next.valid = accept && (row_reg != '0) && (col_reg != '0);
    assign a_tag_next.last  = frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            a_tag_reg <= '0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (advance) begin
                a_tag_reg <= a_tag_next;
            end
        end
    end

    // row store: read-first at the current column
    always_ff @(posedge aclk) begin
        if (accept) begin
            below_reg        <= row_mem[col_reg];
            row_mem[col_reg] <= cell_u;
            left_reg         <= cell_u;
            a_u_reg          <= cell_u;
            a_left_reg       <= left_reg;
        end
    end

    uas_update #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_tag    (a_tag_reg),
        .in_u      (a_u_reg),
        .in_left   (a_left_reg),
        .in_below  (below_reg),
        .x_courant (x_courant_reg),
        .y_courant (y_courant_reg),
        .out_tag   (out_tag),
        .out_value (out_value)
    );

    assign m_tvalid = out_tag.valid;
    assign m_tlast  = out_tag.last;
    assign m_tdata  = TW'($unsigned(out_value));

endmodule
